### rtl/udist_pkg.sv
// ----------------------------------------------------------------------------
// udist_pkg - shared types and constants of the echo distance meter
// Field widths, reciprocal constants for the divisions by constants,
// the seven-segment glyph table and the control and result structs.
// ----------------------------------------------------------------------------
package udist_pkg;

    localparam int TICK_W  = 16;
    localparam int MM_W    = 14;
    localparam int SEG_W   = 8;
    localparam int DIGIT_W = 4;

    localparam int AVG_DEPTH_DEF = 4;

    localparam logic [MM_W-1:0]  LIMIT_RESET = 14'd4000;
    localparam logic [SEG_W-1:0] SEG_DASH    = 8'h40;
    localparam logic [SEG_W-1:0] SEG_DP      = 8'h80;

    // ticks * 10 / 58 == ticks * 5 / 29; ticks * 5 needs 19 bits
    localparam int              TICK5_W     = 19;
    localparam int              DIV29_W     = 20;
    localparam int              DIV29_SHIFT = 24;
    localparam logic [DIV29_W-1:0] DIV29_MUL = 20'd578525;

    // reciprocals for decimal digit extraction of a 14-bit value
    localparam int              DEC_MUL_W     = 15;
    localparam logic [DEC_MUL_W-1:0] DIV10_MUL   = 15'd26215;
    localparam int              DIV10_SHIFT   = 18;
    localparam logic [DEC_MUL_W-1:0] DIV100_MUL  = 15'd20972;
    localparam int              DIV100_SHIFT  = 21;
    localparam logic [DEC_MUL_W-1:0] DIV1000_MUL = 15'd16778;
    localparam int              DIV1000_SHIFT = 24;

    localparam int Q1000_W = 4;
    localparam int Q100_W  = 7;
    localparam int Q10_W   = 11;

    typedef struct packed {
        logic valid;
        logic ovf;
    } t_ctl;

    typedef struct packed {
        logic [MM_W-1:0]  distance_mm;
        logic             out_of_range;
        logic [SEG_W-1:0] seg_thousands;
        logic [SEG_W-1:0] seg_hundreds;
        logic [SEG_W-1:0] seg_tens;
        logic [SEG_W-1:0] seg_units;
    } t_result;

    function automatic logic [SEG_W-1:0] f_glyph(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'h0: seg = 8'h3f;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5b;
            4'h3: seg = 8'h4f;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6d;
            4'h6: seg = 8'h7d;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7f;
            4'h9: seg = 8'h6f;
            4'ha: seg = 8'h77;
            4'hb: seg = 8'h7c;
            4'hc: seg = 8'h39;
            4'hd: seg = 8'h5e;
            4'he: seg = 8'h79;
            4'hf: seg = 8'h71;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

### rtl/udist_if.sv
// ----------------------------------------------------------------------------
// udist_if - channel interfaces of the echo distance meter
// Valid/ready channels for echo measurements, results and the limit write.
// ----------------------------------------------------------------------------
interface udist_echo_if import udist_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] echo_ticks;
    logic              timer_overflow;

    modport source (output valid, echo_ticks, timer_overflow, input ready);
    modport sink   (input valid, echo_ticks, timer_overflow, output ready);
endinterface

interface udist_dist_if import udist_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MM_W-1:0]  distance_mm;
    logic             out_of_range;
    logic [SEG_W-1:0] seg_thousands;
    logic [SEG_W-1:0] seg_hundreds;
    logic [SEG_W-1:0] seg_tens;
    logic [SEG_W-1:0] seg_units;

    modport source (output valid, distance_mm, out_of_range, seg_thousands,
                    seg_hundreds, seg_tens, seg_units, input ready);
    modport sink   (input valid, distance_mm, out_of_range, seg_thousands,
                    seg_hundreds, seg_tens, seg_units, output ready);
endinterface

interface udist_cfg_if import udist_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MM_W-1:0] range_limit_mm;

    modport source (output valid, range_limit_mm, input ready);
    modport sink   (input valid, range_limit_mm, output ready);
endinterface

### rtl/udist_convert.sv
// ----------------------------------------------------------------------------
// udist_convert - input register and tick to millimetre conversion
// Registers the echo transaction, then floor(ticks*5/29) by reciprocal.
// ----------------------------------------------------------------------------
module udist_convert import udist_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_ctl              i_ctl,
    input  logic [TICK_W-1:0] i_ticks,
    output t_ctl              o_ctl,
    output logic [MM_W-1:0]   o_mm
);

    t_ctl                         r_ctl_in;
    logic [TICK_W-1:0]            r_ticks;
    t_ctl                         r_ctl_mm;
    logic [MM_W-1:0]              r_mm;

    logic [TICK5_W-1:0]           ticks5;
    logic [TICK5_W+DIV29_W-1:0]   prod;
    logic [MM_W-1:0]              n_mm;

    assign ticks5 = {1'b0, r_ticks, 2'b00} + {3'b000, r_ticks};
    assign prod   = {{DIV29_W{1'b0}}, ticks5} * {{TICK5_W{1'b0}}, DIV29_MUL};
    assign n_mm   = prod[DIV29_SHIFT +: MM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_in <= '0;
            r_ctl_mm <= '0;
        end else if (i_adv) begin
            r_ctl_in <= i_ctl;
            r_ctl_mm <= r_ctl_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ticks <= i_ticks;
            r_mm    <= n_mm;
        end
    end

    assign o_ctl = r_ctl_mm;
    assign o_mm  = r_mm;

endmodule

### rtl/udist_average.sv
// ----------------------------------------------------------------------------
// udist_average - sample ring and running average
// Writes each distance into the ring, sums it, divides by the depth.
// ----------------------------------------------------------------------------
module udist_average import udist_pkg::*; #(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  t_ctl            i_ctl,
    input  logic [MM_W-1:0] i_mm,
    output t_ctl            o_ctl,
    output logic [MM_W-1:0] o_avg
);

    localparam int SLOT_W    = $clog2(AVG_DEPTH);
    localparam int SUM_W     = MM_W + $clog2(AVG_DEPTH);
    localparam int DEP_SHIFT = SUM_W + $clog2(AVG_DEPTH);
    localparam int MUL_W     = SUM_W + 1;
    localparam logic [MUL_W-1:0] DEP_MUL =
        MUL_W'(((longint'(1) << DEP_SHIFT) + longint'(AVG_DEPTH) - 1) / AVG_DEPTH);

    logic [MM_W-1:0]        r_ring [AVG_DEPTH];
    logic [MM_W-1:0]        n_ring [AVG_DEPTH];
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      n_slot;
    t_ctl                   r_ctl_sum;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;
    t_ctl                   r_ctl_avg;
    logic [MM_W-1:0]        r_avg;
    logic [SUM_W+MUL_W-1:0] prod;

    // ring contents after this transaction lands, and their sum
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < AVG_DEPTH; k++) begin
            n_ring[k] = (r_slot == SLOT_W'(k)) ? i_mm : r_ring[k];
            n_sum     = n_sum + SUM_W'(n_ring[k]);
        end
    end

    assign n_slot = (r_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign prod   = {{MUL_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, DEP_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AVG_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_slot    <= '0;
            r_ctl_sum <= '0;
            r_ctl_avg <= '0;
        end else if (i_adv) begin
            r_ctl_sum <= i_ctl;
            r_ctl_avg <= r_ctl_sum;
            if (i_ctl.valid) begin
                for (int k = 0; k < AVG_DEPTH; k++) begin
                    r_ring[k] <= n_ring[k];
                end
                r_slot <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum <= n_sum;
            r_avg <= prod[DEP_SHIFT +: MM_W];
        end
    end

    assign o_ctl = r_ctl_avg;
    assign o_avg = r_avg;

endmodule

### rtl/udist_digits.sv
// ----------------------------------------------------------------------------
// udist_digits - decimal quotients of the average
// Takes avg/1000, avg/100 and avg/10 side by side by reciprocal multiply.
// ----------------------------------------------------------------------------
module udist_digits import udist_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_ctl               i_ctl,
    input  logic [MM_W-1:0]    i_avg,
    output t_ctl               o_ctl,
    output logic [MM_W-1:0]    o_avg,
    output logic [Q1000_W-1:0] o_q1000,
    output logic [Q100_W-1:0]  o_q100,
    output logic [Q10_W-1:0]   o_q10
);

    localparam int PROD_W = MM_W + DEC_MUL_W;

    t_ctl               r_ctl;
    logic [MM_W-1:0]    r_avg;
    logic [Q1000_W-1:0] r_q1000;
    logic [Q100_W-1:0]  r_q100;
    logic [Q10_W-1:0]   r_q10;
    logic [PROD_W-1:0]  prod1000;
    logic [PROD_W-1:0]  prod100;
    logic [PROD_W-1:0]  prod10;

    assign prod1000 = {{DEC_MUL_W{1'b0}}, i_avg} * {{MM_W{1'b0}}, DIV1000_MUL};
    assign prod100  = {{DEC_MUL_W{1'b0}}, i_avg} * {{MM_W{1'b0}}, DIV100_MUL};
    assign prod10   = {{DEC_MUL_W{1'b0}}, i_avg} * {{MM_W{1'b0}}, DIV10_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_avg   <= i_avg;
            r_q1000 <= prod1000[DIV1000_SHIFT +: Q1000_W];
            r_q100  <= prod100[DIV100_SHIFT +: Q100_W];
            r_q10   <= prod10[DIV10_SHIFT +: Q10_W];
        end
    end

    assign o_ctl   = r_ctl;
    assign o_avg   = r_avg;
    assign o_q1000 = r_q1000;
    assign o_q100  = r_q100;
    assign o_q10   = r_q10;

endmodule

### rtl/udist_display.sv
// ----------------------------------------------------------------------------
// udist_display - digit split, range check and segment encode
// Forms the four digits, picks glyphs or dashes, holds the result register.
// ----------------------------------------------------------------------------
module udist_display import udist_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_ctl               i_ctl,
    input  logic [MM_W-1:0]    i_avg,
    input  logic [Q1000_W-1:0] i_q1000,
    input  logic [Q100_W-1:0]  i_q100,
    input  logic [Q10_W-1:0]   i_q10,
    input  logic [MM_W-1:0]    i_limit,
    output logic               o_valid,
    output t_result            o_res
);

    logic               r_valid;
    t_result            r_res;
    t_result            n_res;
    logic [Q100_W-1:0]  rem_h;
    logic [Q10_W-1:0]   rem_t;
    logic [MM_W-1:0]    rem_u;
    logic               dash;

    // digit = quotient at this place minus ten times the next higher one
    assign rem_h = i_q100 - Q100_W'(Q100_W'(i_q1000) * Q100_W'(10));
    assign rem_t = i_q10 - Q10_W'(Q10_W'(i_q100) * Q10_W'(10));
    assign rem_u = i_avg - MM_W'(MM_W'(i_q10) * MM_W'(10));
    assign dash  = i_ctl.ovf || (i_avg >= i_limit);

    always_comb begin
        n_res.distance_mm  = i_avg;
        n_res.out_of_range = dash;
        if (dash) begin
            n_res.seg_thousands = SEG_DASH;
            n_res.seg_hundreds  = SEG_DASH;
            n_res.seg_tens      = SEG_DASH;
            n_res.seg_units     = SEG_DASH;
        end else begin
            n_res.seg_thousands = f_glyph(i_q1000) | SEG_DP;
            n_res.seg_hundreds  = f_glyph(rem_h[DIGIT_W-1:0]);
            n_res.seg_tens      = f_glyph(rem_t[DIGIT_W-1:0]);
            n_res.seg_units     = f_glyph(rem_u[DIGIT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### rtl/ultrasonic_distance_to_segments.sv
// ----------------------------------------------------------------------------
// ultrasonic_distance_to_segments - echo width to averaged segment readout
// Converts each echo pulse width to millimetres, averages the last
// AVG_DEPTH readings and encodes four seven-segment digits or dashes.
//
//   channel  | dir | fields                                   | handshake
//   ---------+-----+------------------------------------------+-----------
//   i_echo   | in  | echo_ticks, timer_overflow               | valid/ready
//   o_dist   | out | distance_mm, out_of_range, seg_* (4)     | valid/ready
//   i_cfg    | in  | range_limit_mm                           | valid/ready
//
// One transaction is accepted per cycle while o_dist does not stall; each
// yields one result on o_dist through six pipeline registers:
// input register, mm multiply, ring sum, average multiply, digit quotients,
// result register.
// Reset (i_rst_n low, synchronous) empties the pipeline, zeroes the ring
// and the write slot and loads the limit with 4000. Both input channels
// hold ready low while reset is asserted.
// A stall on o_dist freezes every stage at once; i_echo.ready drops in the
// same cycle. The limit register takes a write in every cycle outside reset.
// ----------------------------------------------------------------------------
module ultrasonic_distance_to_segments import udist_pkg::*; #(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    udist_echo_if.sink   i_echo,
    udist_dist_if.source o_dist,
    udist_cfg_if.sink    i_cfg
);

    logic               adv;
    logic [MM_W-1:0]    r_limit;

    t_ctl               in_ctl;
    t_ctl               mm_ctl;
    logic [MM_W-1:0]    mm;
    t_ctl               avg_ctl;
    logic [MM_W-1:0]    avg;
    t_ctl               dig_ctl;
    logic [MM_W-1:0]    dig_avg;
    logic [Q1000_W-1:0] q1000;
    logic [Q100_W-1:0]  q100;
    logic [Q10_W-1:0]   q10;
    logic               out_valid;
    t_result            out_res;

    // advance the whole pipeline while the result register is free or drained
    assign adv          = !out_valid || o_dist.ready;
    assign i_echo.ready = adv && i_rst_n;

    assign in_ctl.valid = i_echo.valid;
    assign in_ctl.ovf   = i_echo.timer_overflow;

    // limit register: the configuration channel never back-pressures outside reset
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.range_limit_mm;
        end
    end

    udist_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (in_ctl),
        .i_ticks (i_echo.echo_ticks),
        .o_ctl   (mm_ctl),
        .o_mm    (mm)
    );

    udist_average #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_average (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (mm_ctl),
        .i_mm    (mm),
        .o_ctl   (avg_ctl),
        .o_avg   (avg)
    );

    udist_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (avg_ctl),
        .i_avg   (avg),
        .o_ctl   (dig_ctl),
        .o_avg   (dig_avg),
        .o_q1000 (q1000),
        .o_q100  (q100),
        .o_q10   (q10)
    );

    udist_display u_display (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (dig_ctl),
        .i_avg   (dig_avg),
        .i_q1000 (q1000),
        .i_q100  (q100),
        .i_q10   (q10),
        .i_limit (r_limit),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    // drive the result channel straight from the result register
    assign o_dist.valid         = out_valid;
    assign o_dist.distance_mm   = out_res.distance_mm;
    assign o_dist.out_of_range  = out_res.out_of_range;
    assign o_dist.seg_thousands = out_res.seg_thousands;
    assign o_dist.seg_hundreds  = out_res.seg_hundreds;
    assign o_dist.seg_tens      = out_res.seg_tens;
    assign o_dist.seg_units     = out_res.seg_units;

endmodule
